// ----- hw/rtl/pfr_pkg.sv -----
`default_nettype none

package pfr_pkg;

    // framing bytes
    localparam logic [7:0] PREAMBLE_BYTE = 8'h55;
    localparam logic [7:0] START0_BYTE   = 8'hD5;
    localparam logic [7:0] START1_BYTE   = 8'h7E;
    localparam logic [7:0] END0_BYTE     = 8'h7D;
    localparam logic [7:0] END1_BYTE     = 8'h0A;
    localparam logic [7:0] TRAIL_BYTE    = 8'h00;

    // payload headroom kept free below max_frame_len
    localparam logic [9:0] CAP_MARGIN = 10'd10;

    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    // request kinds (tuser)
    localparam logic REQ_RECEIVE = 1'b0;
    localparam logic REQ_READ    = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_PROGRESS = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PAYLOAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd3;

    // result waiting for the buffer read data
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  length;
        logic                rd_ok;
    } pfr_stage_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pfr_ram.sv -----
`default_nettype none

module pfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/preamble_frame_receiver.sv -----
// channel      | signals                               | transaction
// -------------+---------------------------------------+------------------------------------
// s_axis       | tvalid tready tdata[15:0] tuser[0:0]  | one request: receive byte or read
// m_axis       | tvalid tready tdata[23:0]             | one result per request
// cfg          | cfg_wr_en cfg_wr_data[8:0]            | write max_frame_len
//
// one request per cycle sustained while the output is not stalled; each result
// passes through the read stage, which holds the frame buffer's registered read
// port, and then through the output register
// the framing state and byte count update in the accept cycle, the byte write
// to the frame buffer happens at the same edge, so a later read always sees it
// reset clears the hunt, the byte count and max_frame_len (256); the frame
// buffer is not cleared
// a stalled output holds the result; the input keeps taking requests until
// both the read stage and the output register are full
`default_nettype none

module preamble_frame_receiver #(
    parameter int BUF_DEPTH = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // rx_byte[7:0], read_index[15:8]
    input  wire logic [0:0]  s_axis_tuser,   // req_type[0]

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,   // rx_status[1:0], frame_length[10:2],
                                             // read_data[18:11], zero fill [23:19]

    input  wire logic        cfg_wr_en,
    input  wire logic [8:0]  cfg_wr_data     // max_frame_len
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    // hunt phases
    localparam logic [3:0] PH_PRE0    = 4'd0;
    localparam logic [3:0] PH_PRE1    = 4'd1;
    localparam logic [3:0] PH_PRE2    = 4'd2;
    localparam logic [3:0] PH_WAIT_D5 = 4'd3;
    localparam logic [3:0] PH_WAIT_7E = 4'd4;
    localparam logic [3:0] PH_PAYLOAD = 4'd5;
    localparam logic [3:0] PH_WAIT_0A = 4'd6;
    localparam logic [3:0] PH_TRAIL0  = 4'd7;
    localparam logic [3:0] PH_TRAIL1  = 4'd8;
    localparam logic [3:0] PH_TRAIL2  = 4'd9;

    // unpacked request fields
    logic       req_type;
    logic [7:0] rx_byte;
    logic [7:0] read_index;

    assign req_type   = s_axis_tuser[0];
    assign rx_byte    = s_axis_tdata[7:0];
    assign read_index = s_axis_tdata[15:8];

    // control state
    logic [3:0]                  phase_reg, phase_next;
    logic [pfr_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [8:0]                  max_len_reg;
    logic                        s1_valid_reg, s1_valid_next;
    logic                        out_valid_reg, out_valid_next;

    // payload stages
    pfr_pkg::pfr_stage_t s1_reg, s1_next;
    logic [23:0]         out_tdata_reg, out_tdata_next;

    logic accept;
    logic advance;

    // buffer write side
    logic                        put;
    logic [pfr_pkg::COUNT_W-1:0] wr_pos;
    logic [31:0]                 wr_pos_ext;
    logic                        wr_en;

    // buffer read side
    logic [31:0] rd_idx_ext;
    logic        rd_ok;
    logic [7:0]  ram_rd_data;
    logic [7:0]  read_data;

    logic                         overflow;
    logic [pfr_pkg::STATUS_W-1:0] status;

    // read stage moves on when the output register is free or being emptied
    assign advance       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // payload byte overflows once count >= max_frame_len - 10 (signed in spirit)
    assign overflow = ({1'b0, count_reg} + pfr_pkg::CAP_MARGIN) >= {1'b0, max_len_reg};

    // framing state machine
    always_comb
    begin
        phase_next = phase_reg;
        status     = pfr_pkg::ST_PROGRESS;
        put        = 1'b0;
        wr_pos     = count_reg;

        unique case (phase_reg)
            PH_PRE0, PH_PRE1, PH_PRE2:
            begin
                // a preamble byte lands at its own position, restarting the buffer
                wr_pos = {5'd0, phase_reg};
                if (rx_byte == pfr_pkg::PREAMBLE_BYTE)
                begin
                    put        = 1'b1;
                    phase_next = phase_reg + 4'd1;
                end
                else
                begin
                    phase_next = PH_PRE0;
                end
            end
            PH_WAIT_D5:
            begin
                if (rx_byte == pfr_pkg::START0_BYTE)
                begin
                    put        = 1'b1;
                    phase_next = PH_WAIT_7E;
                end
                else if (rx_byte != pfr_pkg::PREAMBLE_BYTE)
                begin
                    phase_next = PH_PRE0;
                end
            end
            PH_WAIT_7E:
            begin
                if (rx_byte == pfr_pkg::START1_BYTE)
                begin
                    put        = 1'b1;
                    phase_next = PH_PAYLOAD;
                end
                else
                begin
                    phase_next = PH_PRE0;
                end
            end
            PH_PAYLOAD:
            begin
                if (rx_byte == pfr_pkg::END0_BYTE)
                begin
                    put        = 1'b1;
                    phase_next = PH_WAIT_0A;
                end
                else if (overflow)
                begin
                    status     = pfr_pkg::ST_OVERFLOW;
                    phase_next = PH_PRE0;
                end
                else
                begin
                    put    = 1'b1;
                    status = pfr_pkg::ST_PAYLOAD;
                end
            end
            PH_WAIT_0A:
            begin
                if (rx_byte == pfr_pkg::END1_BYTE)
                begin
                    put        = 1'b1;
                    phase_next = PH_TRAIL0;
                end
                else
                begin
                    phase_next = PH_PRE0;
                end
            end
            PH_TRAIL0, PH_TRAIL1:
            begin
                if (rx_byte == pfr_pkg::TRAIL_BYTE)
                begin
                    put        = 1'b1;
                    phase_next = phase_reg + 4'd1;
                end
                else
                begin
                    phase_next = PH_PRE0;
                end
            end
            PH_TRAIL2:
            begin
                phase_next = PH_PRE0;
                if (rx_byte == pfr_pkg::TRAIL_BYTE)
                begin
                    put    = 1'b1;
                    status = pfr_pkg::ST_DONE;
                end
            end
            default:
            begin
                phase_next = PH_PRE0;
            end
        endcase
    end

    // count follows the write position; positions past the buffer are skipped
    assign count_next = put ? (wr_pos + 9'd1) : count_reg;
    assign wr_pos_ext = 32'(wr_pos);
    assign wr_en      = accept && (req_type == pfr_pkg::REQ_RECEIVE) && put
                        && (wr_pos_ext < 32'(BUF_DEPTH));

    assign rd_idx_ext = 32'(read_index);
    assign rd_ok      = rd_idx_ext < 32'(BUF_DEPTH);

    pfr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_pos_ext[AW-1:0]),
        .wr_data (rx_byte),
        .rd_en   (accept),
        .rd_addr (rd_idx_ext[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // read stage contents for the accepted request
    always_comb
    begin
        s1_next = s1_reg;
        if (accept)
        begin
            if (req_type == pfr_pkg::REQ_READ)
            begin
                s1_next.status = pfr_pkg::ST_PROGRESS;
                s1_next.length = count_reg;
                s1_next.rd_ok  = rd_ok;
            end
            else
            begin
                s1_next.status = status;
                s1_next.length = count_next;
                s1_next.rd_ok  = 1'b0;
            end
        end
    end

    assign read_data = s1_reg.rd_ok ? ram_rd_data : 8'd0;

    assign out_tdata_next = advance
                            ? {5'd0, read_data, s1_reg.length, s1_reg.status}
                            : out_tdata_reg;

    assign s1_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PRE0;
            count_reg     <= '0;
            max_len_reg   <= 9'd256;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && (req_type == pfr_pkg::REQ_RECEIVE))
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
            end
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        s1_reg        <= s1_next;
        out_tdata_reg <= out_tdata_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tdata_reg;

endmodule

`default_nettype wire

// ----- bench/preamble_frame_receiver_test.sv -----
`timescale 1ns / 1ps

// one result word as it leaves the block
typedef struct packed {
    logic [pfr_pkg::STATUS_W-1:0] status;
    logic [pfr_pkg::COUNT_W-1:0]  length;
    logic [7:0]                   rdata;
} frame_result_t;

class frame_tracker;
    localparam int STORE_DEPTH = 256;

    // hunt phases, each one a threshold of the next range
    localparam logic [7:0] PH_WAIT_SOF0 = 8'd3;
    localparam logic [7:0] PH_WAIT_SOF1 = 8'd7;
    localparam logic [7:0] PH_PAYLOAD   = 8'd15;
    localparam logic [7:0] PH_WAIT_END1 = 8'd31;
    localparam logic [7:0] PH_TRAIL     = 8'd63;
    localparam logic [7:0] PH_DONE      = 8'hFF;

    logic [8:0]       max_len;
    logic [7:0]       phase;
    logic [8:0]       count;
    logic [7:0]       store [STORE_DEPTH];
    bit               written [STORE_DEPTH];
    int               seen_slots [$];
    frame_result_t    due_results [$];
    int               errors;

    function new();
        max_len = 9'd256;
        phase   = '0;
        count   = '0;
        errors  = 0;
    endfunction

    function void set_max_len(logic [8:0] value);
        max_len = value;
    endfunction

    function int outstanding();
        return due_results.size();
    endfunction

    // random buffer position that has been written at least once, -1 if none
    function int pick_written();
        if (seen_slots.size() == 0)
            return -1;
        return seen_slots[$urandom_range(0, seen_slots.size() - 1)];
    endfunction

    function void put_byte(logic [7:0] b);
        if (count < STORE_DEPTH)
        begin
            store[count] = b;
            if (!written[count])
            begin
                written[count] = 1'b1;
                seen_slots.push_back(count);
            end
        end
        count = count + 9'd1;
    endfunction

    // advance the deframer by one accepted request and queue its result
    function void note_request(logic req, logic [7:0] b, logic [7:0] idx);
        frame_result_t res;
        logic [8:0]    p;
        res = '0;
        p   = {1'b0, phase};
        if (req == pfr_pkg::REQ_READ)
        begin
            if (written[idx])
                res.rdata = store[idx];
        end
        else if (p < PH_WAIT_SOF0)
        begin
            if (b == pfr_pkg::PREAMBLE_BYTE)
            begin
                count = p;
                put_byte(b);
                phase = phase + 8'd1;
            end
            else
                phase = '0;
        end
        else if (p < PH_WAIT_SOF1)
        begin
            // extra preamble bytes are skipped here
            if (b == pfr_pkg::START0_BYTE)
            begin
                put_byte(b);
                phase = phase + 8'd4;
            end
            else if (b != pfr_pkg::PREAMBLE_BYTE)
                phase = '0;
        end
        else if (p < PH_PAYLOAD)
        begin
            if (b == pfr_pkg::START1_BYTE)
            begin
                put_byte(b);
                phase = phase + 8'd8;
            end
            else
                phase = '0;
        end
        else if (p < PH_WAIT_END1)
        begin
            if (b == pfr_pkg::END0_BYTE)
            begin
                put_byte(b);
                phase = phase + 8'd16;
            end
            else if (int'(count) >= int'(max_len) - int'(pfr_pkg::CAP_MARGIN))
            begin
                phase      = '0;
                res.status = pfr_pkg::ST_OVERFLOW;
            end
            else
            begin
                put_byte(b);
                res.status = pfr_pkg::ST_PAYLOAD;
            end
        end
        else if (p < PH_TRAIL)
        begin
            if (b == pfr_pkg::END1_BYTE)
            begin
                put_byte(b);
                phase = phase + 8'd32;
            end
            else
                phase = '0;
        end
        else if (p < PH_DONE)
        begin
            if (b == pfr_pkg::TRAIL_BYTE)
            begin
                put_byte(b);
                phase = phase + 8'd64;
                if (phase == PH_DONE)
                begin
                    phase      = '0;
                    res.status = pfr_pkg::ST_DONE;
                end
            end
            else
                phase = '0;
        end
        else
            phase = '0;
        res.length = count;
        due_results.push_back(res);
    endfunction

    function void check_result(logic [23:0] word);
        frame_result_t want;
        if (due_results.size() == 0)
        begin
            $error("result with no request pending: tdata %h", word);
            errors++;
            return;
        end
        want = due_results.pop_front();
        if (word[1:0] !== want.status)
        begin
            $error("rx_status expected %0d got %0d", want.status, word[1:0]);
            errors++;
        end
        if (word[10:2] !== want.length)
        begin
            $error("frame_length expected %0d got %0d", want.length, word[10:2]);
            errors++;
        end
        if (word[18:11] !== want.rdata)
        begin
            $error("read_data expected %h got %h", want.rdata, word[18:11]);
            errors++;
        end
    endfunction
endclass

module preamble_frame_receiver_test;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // rx_byte[7:0], read_index[15:8]
    logic [0:0]  s_axis_tuser;    // req_type[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;    // rx_status[1:0], frame_length[10:2], read_data[18:11]
    logic        cfg_wr_en;
    logic [8:0]  cfg_wr_data;

    // predicted deframer state plus the results still owed by the block
    frame_tracker tracker = new();

    // calm stretches: neither side idles while this is set
    bit calm;
    int items_sent;
    int stall_left;

    preamble_frame_receiver u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // result side: random back-pressure, changed on the falling edge
    initial
    begin
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // every result transaction is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tdata);
    end

    // one request transaction; tvalid stays high into the next call when no gap falls
    task automatic push_request(input logic req, input logic [7:0] b,
                                input logic [7:0] idx);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {idx, b};
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_request(req, b, idx);
        items_sent++;
    endtask

    // sometimes read back a buffer position that holds a known byte
    task automatic maybe_read();
        int slot;
        slot = tracker.pick_written();
        if (slot >= 0 && $urandom_range(0, 99) < 12)
            push_request(pfr_pkg::REQ_READ, 8'($urandom), 8'(slot));
    endtask

    task automatic send_rx(input logic [7:0] b);
        push_request(pfr_pkg::REQ_RECEIVE, b, 8'($urandom));
        maybe_read();
    endtask

    // bytes that steer the hunt, used to damage frames and as noise
    function automatic logic [7:0] framing_or_random();
        logic [7:0] marks [6];
        marks = '{pfr_pkg::PREAMBLE_BYTE, pfr_pkg::START0_BYTE, pfr_pkg::START1_BYTE,
                  pfr_pkg::END0_BYTE, pfr_pkg::END1_BYTE, pfr_pkg::TRAIL_BYTE};
        if ($urandom_range(0, 1) == 0)
            return marks[$urandom_range(0, 5)];
        return 8'($urandom);
    endfunction

    // whole frame with random payload; a damaged frame has one byte replaced
    task automatic send_frame(input int body_len, input bit damage);
        logic [7:0] bytes [$];
        logic [7:0] v;
        int         pos;
        repeat (3 + $urandom_range(0, 3)) bytes.push_back(pfr_pkg::PREAMBLE_BYTE);
        bytes.push_back(pfr_pkg::START0_BYTE);
        bytes.push_back(pfr_pkg::START1_BYTE);
        repeat (body_len)
        begin
            v = 8'($urandom);
            // a payload 7D would already start the end check
            if (v == pfr_pkg::END0_BYTE)
                v = ~v;
            bytes.push_back(v);
        end
        bytes.push_back(pfr_pkg::END0_BYTE);
        bytes.push_back(pfr_pkg::END1_BYTE);
        repeat (3) bytes.push_back(pfr_pkg::TRAIL_BYTE);
        if (damage)
        begin
            pos = $urandom_range(0, bytes.size() - 1);
            bytes[pos] = framing_or_random();
        end
        foreach (bytes[i])
            send_rx(bytes[i]);
    endtask

    // lower tvalid, wait for every owed result, then let the pipeline settle
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [8:0] value);
        drain_results();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 9'($urandom);
        tracker.set_max_len(value);
    endtask

    // mix of clean frames, damaged frames and loose noise bytes
    task automatic run_phase(input int quota);
        int start;
        int r;
        int len;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            calm = ($urandom_range(0, 5) == 0);
            r    = $urandom_range(0, 99);
            if (r < 10)
            begin
                repeat ($urandom_range(1, 6)) send_rx(framing_or_random());
            end
            else
            begin
                // long frames reach the overflow limit and the upper buffer half
                if ($urandom_range(0, 14) == 0)
                    len = $urandom_range(0, int'(tracker.max_len));
                else
                    len = $urandom_range(0, 12);
                send_frame(len, r < 28);
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        logic [8:0] settings [6];
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = pfr_pkg::REQ_RECEIVE;
        m_axis_tready = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        calm          = 1'b0;
        items_sent    = 0;
        settings      = '{9'd16, 9'd256, 9'd100, 9'd17, 9'd200, 9'd256};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // clean frame with extra preamble byte and payload extremes
        send_rx(pfr_pkg::PREAMBLE_BYTE);
        send_rx(pfr_pkg::PREAMBLE_BYTE);
        send_rx(pfr_pkg::PREAMBLE_BYTE);
        send_rx(pfr_pkg::PREAMBLE_BYTE);
        send_rx(pfr_pkg::START0_BYTE);
        send_rx(pfr_pkg::START1_BYTE);
        send_rx(8'h00);
        send_rx(8'hFF);
        send_rx(pfr_pkg::END1_BYTE);
        send_rx(pfr_pkg::END0_BYTE);
        send_rx(pfr_pkg::END1_BYTE);
        send_rx(pfr_pkg::TRAIL_BYTE);
        send_rx(pfr_pkg::TRAIL_BYTE);
        send_rx(pfr_pkg::TRAIL_BYTE);
        // first and last stored bytes of that frame
        push_request(pfr_pkg::REQ_READ, 8'hFF, 8'd0);
        push_request(pfr_pkg::REQ_READ, 8'h00, 8'd12);
        // stray byte drops the hunt, next preamble restarts at position zero
        send_rx(pfr_pkg::PREAMBLE_BYTE);
        send_rx(8'hAA);
        // payload 7D not followed by 0A drops the frame
        send_rx(pfr_pkg::PREAMBLE_BYTE);
        send_rx(pfr_pkg::PREAMBLE_BYTE);
        send_rx(pfr_pkg::PREAMBLE_BYTE);
        send_rx(pfr_pkg::START0_BYTE);
        send_rx(pfr_pkg::START1_BYTE);
        send_rx(pfr_pkg::END0_BYTE);
        send_rx(8'h99);

        foreach (settings[i])
        begin
            write_max_len(settings[i]);
            run_phase(115);
        end

        drain_results();
        if (tracker.errors == 0)
            $display("preamble_frame_receiver test passed");
        else
            $display("preamble_frame_receiver test failed");
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("preamble_frame_receiver test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/pfr_pkg.sv
hw/rtl/pfr_ram.sv
hw/rtl/preamble_frame_receiver.sv
bench/preamble_frame_receiver_test.sv
